// ===== hdl/dvt_pkg.sv =====
// ----------------------------------------------------------------------------
// dvt_pkg
// Shared constants, types and controller/datapath signal groups for the
// distance-vector routing table.
// ----------------------------------------------------------------------------
package dvt_pkg;

    // table geometry
    localparam int ENTRIES  = 64;
    localparam int ADDR_W   = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    // item field widths
    localparam int KIND_W   = 2;
    localparam int NODE_W   = 8;
    localparam int COST_W   = 16;
    localparam int INDEX_W  = 7;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_UPDATE = 2'd0,
        KIND_RELAX  = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_UNCHANGED   = 3'd0,
        STAT_IMPROVED    = 3'd1,
        STAT_ADDED       = 3'd2,
        STAT_VIA_UNKNOWN = 3'd3,
        STAT_TABLE_FULL  = 3'd4
    } status_t;

    typedef struct packed {
        logic [NODE_W-1:0] dest;
        logic [NODE_W-1:0] hop;
        logic [COST_W-1:0] cost;
    } route_t;

    localparam int ROUTE_W = $bits(route_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_FIRST,
        S_SUM,
        S_SCAN_SECOND,
        S_IMPROVE,
        S_APPEND,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan_run;
        logic    scan_tgt;
        logic    add_cost;
        logic    write_found;
        logic    append;
        logic    set_status;
        status_t status;
        logic    rd_issue;
        logic    rd_capture;
        logic    push;
    } dvt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_hit;
        logic scan_miss;
        logic better;
        logic full;
        logic out_free;
    } dvt_sts_t;

endpackage

// ===== hdl/dvt_req_if.sv =====
// ----------------------------------------------------------------------------
// dvt_req_if
// Request channel: valid/ready handshake carrying one table operation.
// ----------------------------------------------------------------------------
interface dvt_req_if;
    import dvt_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  target;
    logic [NODE_W-1:0]  next_hop;
    logic [COST_W-1:0]  cost;
    logic [INDEX_W-1:0] index;

    modport source (output valid, kind, node, target, next_hop, cost, index,
                    input ready);
    modport sink   (input valid, kind, node, target, next_hop, cost, index,
                    output ready);

endinterface

// ===== hdl/dvt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dvt_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface dvt_rsp_if;
    import dvt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                entry_valid;
    logic [NODE_W-1:0]   entry_dest;
    logic [NODE_W-1:0]   entry_next;
    logic [COST_W-1:0]   entry_cost;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, entry_valid, entry_dest, entry_next,
                    entry_cost, entry_count, input ready);
    modport sink   (input valid, status, entry_valid, entry_dest, entry_next,
                    entry_cost, entry_count, output ready);

endinterface

// ===== hdl/dvt_ram.sv =====
// ----------------------------------------------------------------------------
// dvt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/dvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dvt_ctrl
// Sequencer for update, relax and read items; drives the datapath by command.
// ----------------------------------------------------------------------------
module dvt_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic [dvt_pkg::KIND_W-1:0] req_kind,
    output logic                      req_ready,
    input  dvt_pkg::dvt_sts_t         sts,
    output dvt_pkg::dvt_cmd_t         cmd
);
    import dvt_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [KIND_W-1:0] kind_reg;
    logic [KIND_W-1:0] kind_next;
    logic              req_fire;
    logic              is_relax;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign is_relax  = (kind_reg == KIND_RELAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_UPDATE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    kind_next = req_kind;
                    case (req_kind)
                        KIND_UPDATE: state_next = S_SCAN_FIRST;
                        KIND_RELAX:  state_next = S_SCAN_FIRST;
                        KIND_READ:   state_next = S_RD_ISSUE;
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_SCAN_FIRST:
            begin
                if (sts.scan_hit)
                begin
                    state_next = is_relax ? S_SUM : S_IMPROVE;
                end
                else if (sts.scan_miss)
                begin
                    state_next = is_relax ? S_RESP : S_APPEND;
                end
            end
            S_SUM:
            begin
                state_next = S_SCAN_SECOND;
            end
            S_SCAN_SECOND:
            begin
                if (sts.scan_hit)
                begin
                    state_next = S_IMPROVE;
                end
                else if (sts.scan_miss)
                begin
                    state_next = S_APPEND;
                end
            end
            S_IMPROVE:  state_next = S_RESP;
            S_APPEND:   state_next = S_RESP;
            S_RD_ISSUE: state_next = S_RD_WAIT;
            S_RD_WAIT:  state_next = S_RESP;
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        cmd.status = STAT_UNCHANGED;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = req_fire;
            end
            S_SCAN_FIRST:
            begin
                cmd.scan_run = 1'b1;
                if (!sts.scan_hit && sts.scan_miss && is_relax)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STAT_VIA_UNKNOWN;
                end
            end
            S_SUM:
            begin
                cmd.add_cost = 1'b1;
                cmd.scan_tgt = 1'b1;
            end
            S_SCAN_SECOND:
            begin
                cmd.scan_run = 1'b1;
            end
            S_IMPROVE:
            begin
                if (sts.better)
                begin
                    cmd.write_found = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status      = STAT_IMPROVED;
                end
            end
            S_APPEND:
            begin
                cmd.set_status = 1'b1;
                if (sts.full)
                begin
                    cmd.status = STAT_TABLE_FULL;
                end
                else
                begin
                    cmd.append = 1'b1;
                    cmd.status = STAT_ADDED;
                end
            end
            S_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
            end
            S_RD_WAIT:
            begin
                cmd.rd_capture = 1'b1;
            end
            S_RESP:
            begin
                cmd.push = sts.out_free;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/dvt_dp.sv =====
// ----------------------------------------------------------------------------
// dvt_dp
// Route storage, pipelined search, cost arithmetic and result register.
// ----------------------------------------------------------------------------
module dvt_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dvt_pkg::dvt_cmd_t           cmd,
    output dvt_pkg::dvt_sts_t           sts,
    input  logic [dvt_pkg::KIND_W-1:0]  req_kind,
    input  logic [dvt_pkg::NODE_W-1:0]  req_node,
    input  logic [dvt_pkg::NODE_W-1:0]  req_target,
    input  logic [dvt_pkg::NODE_W-1:0]  req_next_hop,
    input  logic [dvt_pkg::COST_W-1:0]  req_cost,
    input  logic [dvt_pkg::INDEX_W-1:0] req_index,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [dvt_pkg::STATUS_W-1:0] rsp_status,
    output logic                        rsp_entry_valid,
    output logic [dvt_pkg::NODE_W-1:0]  rsp_entry_dest,
    output logic [dvt_pkg::NODE_W-1:0]  rsp_entry_next,
    output logic [dvt_pkg::COST_W-1:0]  rsp_entry_cost,
    output logic [dvt_pkg::COUNT_W-1:0] rsp_entry_count
);
    import dvt_pkg::*;

    // control state
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;

    // item operands
    logic [NODE_W-1:0]  key_reg;
    logic [NODE_W-1:0]  upd_dest_reg;
    logic [NODE_W-1:0]  upd_hop_reg;
    logic [COST_W-1:0]  upd_cost_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [ADDR_W-1:0]  pend_addr_reg;
    logic [ADDR_W-1:0]  found_pos_reg;
    logic [COST_W-1:0]  found_cost_reg;
    status_t            status_reg;
    logic               e_valid_reg;
    route_t             e_data_reg;

    // result register
    status_t            o_status_reg;
    logic               o_valid_reg;
    route_t             o_data_reg;
    logic [COUNT_W-1:0] o_count_reg;

    // ram port
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    route_t             ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    route_t             ram_rd_data;

    logic                       scan_issue;
    logic                       match;
    logic [INDEX_W+ADDR_W-1:0]  idx_addr_ext;
    logic [INDEX_W+CNT_W-1:0]   idx_wide;
    logic [INDEX_W+CNT_W-1:0]   fill_wide;
    logic                       in_range;
    logic [COUNT_W+CNT_W-1:0]   count_ext;

    dvt_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (ENTRIES)
    ) u_dvt_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign scan_issue   = cmd.scan_run && (ptr_reg < fill_reg);
    assign match        = pend_reg && (ram_rd_data.dest == key_reg);
    assign idx_addr_ext = {{ADDR_W{1'b0}}, index_reg};
    assign idx_wide     = {{CNT_W{1'b0}}, index_reg};
    assign fill_wide    = {{INDEX_W{1'b0}}, fill_reg};
    assign in_range     = idx_wide < fill_wide;
    assign count_ext    = {{COUNT_W{1'b0}}, fill_reg};

    assign ram_rd_en    = scan_issue || cmd.rd_issue;
    assign ram_rd_addr  = cmd.rd_issue ? idx_addr_ext[ADDR_W-1:0] : ptr_reg[ADDR_W-1:0];
    assign ram_wr_en    = cmd.write_found || cmd.append;
    assign ram_wr_addr  = cmd.write_found ? found_pos_reg : fill_reg[ADDR_W-1:0];
    assign ram_wr_data  = '{dest: upd_dest_reg, hop: upd_hop_reg, cost: upd_cost_reg};

    assign sts.scan_hit  = match;
    assign sts.scan_miss = !pend_reg && !(ptr_reg < fill_reg);
    assign sts.better    = found_cost_reg > upd_cost_reg;
    assign sts.full      = (fill_reg == CNT_W'(ENTRIES));
    assign sts.out_free  = !out_valid_reg || rsp_ready;

    // control next values
    always_comb
    begin
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        pend_next = pend_reg;
        if (cmd.append)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.load || cmd.scan_tgt)
        begin
            ptr_next  = '0;
            pend_next = 1'b0;
        end
        else if (cmd.scan_run)
        begin
            pend_next = scan_issue;
            if (scan_issue)
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
        end
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // operand and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg      <= req_node;
            index_reg    <= req_index;
            upd_cost_reg <= req_cost;
            status_reg   <= STAT_UNCHANGED;
            e_valid_reg  <= 1'b0;
            e_data_reg   <= '0;
            if (req_kind == KIND_RELAX)
            begin
                upd_dest_reg <= req_target;
                upd_hop_reg  <= req_node;
            end
            else
            begin
                upd_dest_reg <= req_node;
                upd_hop_reg  <= req_next_hop;
            end
        end
        if (scan_issue)
        begin
            pend_addr_reg <= ptr_reg[ADDR_W-1:0];
        end
        if (cmd.scan_run && match)
        begin
            found_pos_reg  <= pend_addr_reg;
            found_cost_reg <= ram_rd_data.cost;
        end
        // relax: path cost through the neighbour, wraps at 16 bits
        if (cmd.add_cost)
        begin
            upd_cost_reg <= upd_cost_reg + found_cost_reg;
        end
        if (cmd.scan_tgt)
        begin
            key_reg <= upd_dest_reg;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.rd_capture)
        begin
            e_valid_reg <= in_range;
            e_data_reg  <= in_range ? ram_rd_data : '0;
        end
        if (cmd.push)
        begin
            o_status_reg <= status_reg;
            o_valid_reg  <= e_valid_reg;
            o_data_reg   <= e_data_reg;
            o_count_reg  <= count_ext[COUNT_W-1:0];
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp_status      = o_status_reg;
    assign rsp_entry_valid = o_valid_reg;
    assign rsp_entry_dest  = o_data_reg.dest;
    assign rsp_entry_next  = o_data_reg.hop;
    assign rsp_entry_cost  = o_data_reg.cost;
    assign rsp_entry_count = o_count_reg;

endmodule

// ===== hdl/distance_vector_table.sv =====
// ----------------------------------------------------------------------------
// distance_vector_table
// Distance-vector routing table with update, relax and indexed read items.
// ----------------------------------------------------------------------------
// usage
//   req: one item per handshake; kind selects update, relax via a neighbour
//     or read by index; the other fields are used as the kind needs them
//   rsp: exactly one result item per request item, in order; status,
//     the read entry (zeros unless a read hit a held route) and the
//     number of routes held after the item
// throughput
//   one item at a time; a new item is taken once the previous one has
//   been placed in the result register and the sequencer is back in idle
//   search is one route per cycle through the route ram (registered read)
// reset
//   clears the route count and all control state; no clearing pass, route
//   ram contents are only used below the count
// stall
//   a waiting result does not block acceptance of the next item; that
//   item finishes its work and then holds until the result register frees
// ----------------------------------------------------------------------------
module distance_vector_table (
    input  logic       clk,
    input  logic       rst_n,
    dvt_req_if.sink    req,
    dvt_rsp_if.source  rsp
);
    import dvt_pkg::*;

    dvt_cmd_t cmd;
    dvt_sts_t sts;

    // sequencer
    dvt_ctrl u_dvt_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage, search and result register
    dvt_dp u_dvt_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .req_kind        (req.kind),
        .req_node        (req.node),
        .req_target      (req.target),
        .req_next_hop    (req.next_hop),
        .req_cost        (req.cost),
        .req_index       (req.index),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_status      (rsp.status),
        .rsp_entry_valid (rsp.entry_valid),
        .rsp_entry_dest  (rsp.entry_dest),
        .rsp_entry_next  (rsp.entry_next),
        .rsp_entry_cost  (rsp.entry_cost),
        .rsp_entry_count (rsp.entry_count)
    );

endmodule

// ===== hdl/dvt_checker.sv =====
// ----------------------------------------------------------------------------
// dvt_checker
// Port-level checks of the routing table, bound to the top level.
// ----------------------------------------------------------------------------
module dvt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [dvt_pkg::STATUS_W-1:0] rsp_status,
    input logic                         rsp_entry_valid,
    input logic [dvt_pkg::NODE_W-1:0]   rsp_entry_dest,
    input logic [dvt_pkg::NODE_W-1:0]   rsp_entry_next,
    input logic [dvt_pkg::COST_W-1:0]   rsp_entry_cost,
    input logic [dvt_pkg::COUNT_W-1:0]  rsp_entry_count
);
    import dvt_pkg::*;

    // one item at a time: accepting an item closes the request side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while an item is in progress");

    // held result keeps its count
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count))
        else $error("stalled result dropped or changed");

    // only a read fills the entry fields, and a read reports unchanged
    a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_entry_valid |-> rsp_status == STAT_UNCHANGED)
        else $error("valid entry with non-read status");

    a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_entry_valid |->
            rsp_entry_dest == '0 && rsp_entry_next == '0 && rsp_entry_cost == '0)
        else $error("entry fields not cleared without a valid entry");

    // table full only when the count has reached capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == STAT_TABLE_FULL |->
            rsp_entry_count == COUNT_W'(ENTRIES))
        else $error("table full reported below capacity");

endmodule

bind distance_vector_table dvt_checker u_dvt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_entry_valid (rsp.entry_valid),
    .rsp_entry_dest  (rsp.entry_dest),
    .rsp_entry_next  (rsp.entry_next),
    .rsp_entry_cost  (rsp.entry_cost),
    .rsp_entry_count (rsp.entry_count)
);
